>>> hdl/shape_edge_record_codec_defines.svh
// Assertion macros shared by the codec checker.
// No dependencies; include once per file that asserts.
`ifndef SHAPE_EDGE_RECORD_CODEC_DEFINES_SVH
`define SHAPE_EDGE_RECORD_CODEC_DEFINES_SVH

// same-cycle implication
`define SEC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication
`define SEC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> hdl/sec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shape edge record codec.
// No dependencies; used by the decode, encode and top-level files.
package sec_pkg;

	localparam int MIN_DELTA_BITS = 2;
	localparam int WINDOW_BITS    = 80;
	localparam int ENCODE_CAP     = 17;
	localparam int OFF_BITS       = 8;
	localparam int LEN_BITS       = 7;

	typedef enum logic [1:0] {
		CMD_DECODE = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_MOVE   = 2'd2
	} sec_cmd_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} sec_point_t;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] record;
		logic [LEN_BITS-1:0]    bit_length;
		logic                   type_bit;
		logic                   is_curve;
		logic [3:0]             size_code;
		sec_point_t             ctrl;
		sec_point_t             end_pt;
		logic                   status;
	} sec_result_t;

endpackage

>>> hdl/sec_decode.sv
`timescale 1ns / 1ps
// Edge record parser: field extraction from the 80-bit window plus pen adds.
// Depends on sec_pkg.
module sec_decode #(
	parameter int SIZE_FIELD_BITS = 4
) (
	input  logic [sec_pkg::WINDOW_BITS-1:0] window,
	input  sec_pkg::sec_point_t             pen,
	output sec_pkg::sec_result_t            res
);

	localparam int DW  = (1 << SIZE_FIELD_BITS) + sec_pkg::MIN_DELTA_BITS - 1;
	localparam int HDR = 2 + SIZE_FIELD_BITS;
	localparam int XW  = sec_pkg::WINDOW_BITS + DW;
	localparam int OW  = sec_pkg::OFF_BITS;

	logic [SIZE_FIELD_BITS-1:0] code;
	logic                       straight, general, vertical;
	logic [OW-1:0]              w, h, off0, off1, off2, off3, len;
	logic signed [31:0]         e0, e1, e2, e3;
	logic signed [31:0]         fx, fy, sx, sy;
	sec_pkg::sec_point_t        mid, fin;

	function automatic logic signed [31:0] field_at(
		input logic [sec_pkg::WINDOW_BITS-1:0] win,
		input logic [OW-1:0]                   off,
		input logic [OW-1:0]                   width
	);
		logic [XW-1:0]        wide;
		logic signed [DW-1:0] top;
		wide = {win, {DW{1'b0}}} << off;
		top  = wide[XW-1 -: DW];
		top  = top >>> (OW'(DW) - width);
		return 32'(top);
	endfunction

	assign straight = window[sec_pkg::WINDOW_BITS-2];
	assign code     = window[sec_pkg::WINDOW_BITS-3 -: SIZE_FIELD_BITS];
	assign general  = window[sec_pkg::WINDOW_BITS-1-HDR];
	assign vertical = window[sec_pkg::WINDOW_BITS-2-HDR];
	assign w        = OW'(code) + OW'(sec_pkg::MIN_DELTA_BITS);
	assign h        = OW'(HDR);

	assign off0 = !straight ? h : (general ? h + OW'(1) : h + OW'(2));
	assign off1 = !straight ? h + w : h + OW'(1) + w;
	assign off2 = h + (w << 1);
	assign off3 = h + w + (w << 1);

	assign e0 = field_at(window, off0, w);
	assign e1 = field_at(window, off1, w);
	assign e2 = field_at(window, off2, w);
	assign e3 = field_at(window, off3, w);

	always_comb begin
		fx = (!straight || general || !vertical) ? e0 : '0;
		if (!straight || general) begin
			fy = e1;
		end else begin
			fy = vertical ? e0 : '0;
		end
		sx = !straight ? e2 : '0;
		sy = !straight ? e3 : '0;
	end

	assign mid.x = pen.x + fx;
	assign mid.y = pen.y + fy;
	assign fin.x = mid.x + sx;
	assign fin.y = mid.y + sy;

	assign len = !straight ? h + (w << 2) :
		(general ? h + OW'(1) + (w << 1) : h + OW'(2) + w);

	always_comb begin
		res            = '0;
		res.bit_length = (len > OW'(127)) ? 7'd127 : len[sec_pkg::LEN_BITS-1:0];
		res.type_bit   = window[sec_pkg::WINDOW_BITS-1];
		res.is_curve   = !straight;
		res.size_code  = 4'(code);
		res.ctrl       = mid;
		res.end_pt     = fin;
	end

endmodule

>>> hdl/sec_encode.sv
`timescale 1ns / 1ps
// Edge record packer: deltas, minimum delta width and left-aligned packing.
// Depends on sec_pkg.
module sec_encode #(
	parameter int SIZE_FIELD_BITS = 4
) (
	input  logic                 is_curve,
	input  sec_pkg::sec_point_t  pen,
	input  sec_pkg::sec_point_t  pt_a,
	input  sec_pkg::sec_point_t  pt_b,
	output sec_pkg::sec_result_t res
);

	localparam int FULL = (1 << SIZE_FIELD_BITS) + sec_pkg::MIN_DELTA_BITS - 1;
	localparam int EW   = (FULL < sec_pkg::ENCODE_CAP) ? FULL : sec_pkg::ENCODE_CAP;
	localparam int HDR  = 2 + SIZE_FIELD_BITS;
	localparam int WB   = sec_pkg::WINDOW_BITS;
	localparam int XW   = WB + EW;
	localparam int OW   = sec_pkg::OFF_BITS;

	sec_pkg::sec_point_t first;
	logic signed [32:0]  d0, d1, d2, d3;
	logic [31:0]         spread;
	logic [4:0]          msb;
	logic [OW-1:0]       w, h, code_w, off0, off1, off2, off3, len;
	logic                too_wide, general, xonly;
	logic [EW-1:0]       v0, v1;
	logic [WB-1:0]       hdr, record;

	function automatic logic [31:0] flips(input logic signed [32:0] v);
		return v[31:0] ^ v[32:1];
	endfunction

	function automatic logic [WB-1:0] place(
		input logic [EW-1:0] v,
		input logic [OW-1:0] width,
		input logic [OW-1:0] off
	);
		logic [EW-1:0] la;
		logic [XW-1:0] wide;
		la   = v << (OW'(EW) - width);
		wide = {la, {WB{1'b0}}} >> off;
		return wide[XW-1 -: WB];
	endfunction

	assign first = is_curve ? pt_a : pt_b;
	assign d0 = 33'(first.x) - 33'(pen.x);
	assign d1 = 33'(first.y) - 33'(pen.y);
	assign d2 = is_curve ? 33'(pt_b.x) - 33'(pt_a.x) : '0;
	assign d3 = is_curve ? 33'(pt_b.y) - 33'(pt_a.y) : '0;

	assign spread = flips(d0) | flips(d1) | flips(d2) | flips(d3);

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (spread[i]) begin
				msb = 5'(i);
			end
		end
	end

	assign w        = (spread == '0) ? OW'(sec_pkg::MIN_DELTA_BITS) : OW'(msb) + OW'(2);
	assign too_wide = w > OW'(EW);
	assign code_w   = w - OW'(sec_pkg::MIN_DELTA_BITS);
	assign h        = OW'(HDR);

	assign general = (d0 != '0) && (d1 != '0);
	assign xonly   = (d0 != '0) && (d1 == '0);

	assign v0 = (is_curve || general || xonly) ? d0[EW-1:0] : d1[EW-1:0];
	assign v1 = (is_curve || general) ? d1[EW-1:0] : '0;

	assign off0 = is_curve ? h : (general ? h + OW'(1) : h + OW'(2));
	assign off1 = is_curve ? h + w : h + OW'(1) + w;
	assign off2 = h + (w << 1);
	assign off3 = h + w + (w << 1);

	always_comb begin
		hdr                                = '0;
		hdr[WB-1]                          = 1'b1;
		hdr[WB-2]                          = !is_curve;
		hdr[WB-3 -: SIZE_FIELD_BITS]       = code_w[SIZE_FIELD_BITS-1:0];
		hdr[WB-1-HDR]                      = !is_curve && general;
		hdr[WB-2-HDR]                      = !is_curve && !general && !xonly;
	end

	assign record = hdr | place(v0, w, off0) | place(v1, w, off1)
		| place(d2[EW-1:0], w, off2) | place(d3[EW-1:0], w, off3);

	assign len = is_curve ? h + (w << 2) :
		(general ? h + OW'(1) + (w << 1) : h + OW'(2) + w);

	always_comb begin
		res = '0;
		if (too_wide) begin
			res.status = 1'b1;
		end else begin
			res.record     = record;
			res.bit_length = len[sec_pkg::LEN_BITS-1:0];
			res.type_bit   = 1'b1;
			res.is_curve   = is_curve;
			res.size_code  = code_w[3:0];
			res.ctrl       = is_curve ? pt_a : pt_b;
			res.end_pt     = pt_b;
		end
	end

endmodule

>>> hdl/shape_edge_record_codec.sv
`timescale 1ns / 1ps
// Top level of the shape edge record codec: input stage, pen register, result stage.
// Depends on sec_pkg, sec_decode and sec_encode.
//
//  channel   | dir | tdata                       | tuser
//  s_axis    | in  | window, curve flag, points  | command
//  m_axis    | out | record, length, kind, points| status
//
// One word per cycle unless the output stalls; words pass input then result stage.
// The pen register is updated as a word leaves the input stage, so the next word
// already sees it. arst_n clears both stage valids and the pen (to zero).
// A stalled output holds its word; the input stage still takes one more word.
module shape_edge_record_codec #(
	parameter int SIZE_FIELD_BITS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// window_low[63:0], window_high[79:64], is_curve_in[80], point_a_x[112:81],
	// point_a_y[144:113], point_b_x[176:145], point_b_y[208:177], zero pad
	input  logic [215:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// packed_low[63:0], packed_high[79:64], bit_length[86:80], type_bit[87],
	// is_curve_out[88], size_code[92:89], ctrl_x[124:93], ctrl_y[156:125],
	// end_x[188:157], end_y[220:189], zero pad
	output logic [223:0] m_axis_tdata,
	// status[0]
	output logic [0:0]   m_axis_tuser
);

	logic                   valid_s1, valid_s2;
	logic [1:0]             cmd_s1;
	logic [79:0]            window_s1;
	logic                   curve_s1;
	sec_pkg::sec_point_t    pt_a_s1, pt_b_s1;
	sec_pkg::sec_point_t    pen_q, pen_next;
	sec_pkg::sec_result_t   dec_res, enc_res, res, res_s2;
	logic                   take, advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;

	sec_decode #(.SIZE_FIELD_BITS(SIZE_FIELD_BITS)) u_decode (
		.window (window_s1),
		.pen    (pen_q),
		.res    (dec_res)
	);

	sec_encode #(.SIZE_FIELD_BITS(SIZE_FIELD_BITS)) u_encode (
		.is_curve (curve_s1),
		.pen      (pen_q),
		.pt_a     (pt_a_s1),
		.pt_b     (pt_b_s1),
		.res      (enc_res)
	);

	always_comb begin
		res      = '0;
		pen_next = pen_q;
		case (sec_pkg::sec_cmd_t'(cmd_s1))
			sec_pkg::CMD_DECODE: begin
				res      = dec_res;
				pen_next = dec_res.end_pt;
			end
			sec_pkg::CMD_ENCODE: begin
				res = enc_res;
				if (!enc_res.status) begin
					pen_next = pt_b_s1;
				end
			end
			sec_pkg::CMD_MOVE: begin
				res.ctrl   = pt_b_s1;
				res.end_pt = pt_b_s1;
				pen_next   = pt_b_s1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pen_q    <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				pen_q    <= pen_next;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1    <= s_axis_tuser;
			window_s1 <= s_axis_tdata[79:0];
			curve_s1  <= s_axis_tdata[80];
			pt_a_s1   <= {s_axis_tdata[112:81], s_axis_tdata[144:113]};
			pt_b_s1   <= {s_axis_tdata[176:145], s_axis_tdata[208:177]};
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.end_pt.y, res_s2.end_pt.x,
		res_s2.ctrl.y, res_s2.ctrl.x, res_s2.size_code, res_s2.is_curve,
		res_s2.type_bit, res_s2.bit_length, res_s2.record};
	assign m_axis_tuser  = res_s2.status;

endmodule

>>> hdl/sec_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the shape edge record codec, bound to the top level.
// Depends on shape_edge_record_codec_defines.svh and shape_edge_record_codec.
`include "shape_edge_record_codec_defines.svh"

module sec_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [223:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	`SEC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`SEC_ASSERT_IMP(a_err_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
	`SEC_ASSERT_IMP(a_rec_type, clk, arst_n, m_axis_tvalid && m_axis_tdata[79], m_axis_tdata[87])
	`SEC_ASSERT_IMP(a_rec_kind, clk, arst_n, m_axis_tvalid && m_axis_tdata[79], m_axis_tdata[78] != m_axis_tdata[88])
	`SEC_ASSERT_IMP(a_in_free, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind shape_edge_record_codec sec_checker u_sec_checker (.*);
